// ----- src/bli_pkg.sv -----
package bli_pkg;

    localparam int POS_W  = 32;
    localparam int BRG_W  = 9;
    localparam int DIR_W  = 22;
    localparam int DIFF_W = 33;
    localparam int DEN_W  = 43;
    localparam int DABS_W = 42;
    localparam int NUM_W  = 54;
    localparam int LO_W   = 27;
    localparam int PLO_W  = DIR_W + LO_W + 1;
    localparam int PHI_W  = DIR_W + NUM_W - LO_W;
    localparam int MUL_W  = 78;
    localparam int MAG_W  = 77;
    localparam int QUOT_W = 40;
    localparam int DIV_W  = DABS_W + 1;
    localparam int CMP_W  = 84;
    localparam int OFF_W  = 42;
    localparam int SUM_W  = 43;
    localparam int TAB_N  = 91;
    localparam int FRONT_N = 8;
    localparam int STAGE_N = FRONT_N + QUOT_W + 2;

    localparam logic [BRG_W-1:0] DEG_90  = 9'd90;
    localparam logic [BRG_W-1:0] DEG_180 = 9'd180;
    localparam logic [BRG_W-1:0] DEG_270 = 9'd270;
    localparam logic [BRG_W-1:0] DEG_360 = 9'd360;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned DIR_ONE = 64'd1048576;

    // (2n)(2n+1) for taylor terms n = 1..8
    localparam longint unsigned TAYLOR_DEN [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                     64'd110, 64'd156, 64'd210, 64'd272};

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fffffff;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

    typedef logic [20:0] sin_val_t;
    typedef sin_val_t sin_tab_t [0:TAB_N-1];

    typedef struct packed {
        logic [MAG_W-1:0]  rem;
        logic [QUOT_W-1:0] quo;
        logic              neg;
    } div_lane_t;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic [DIV_W-1:0]        div2;
        logic                    par;
    } div_side_t;

    // taylor series evaluated at elaboration only
    function automatic sin_val_t quarter_sine(int unsigned deg);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        x = (longint'(deg) * PI_Q30 + 64'd90) / 64'd180;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DEN[n];
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (longint'(sum) + 64'd512) >> 10;
        if (r > DIR_ONE)
            r = DIR_ONE;
        return r[20:0];
    endfunction

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t t;
        for (int i = 0; i < TAB_N; i++)
        begin
            t[i] = quarter_sine(i);
        end
        return t;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    // a is already below 360
    function automatic logic signed [DIR_W-1:0] sin_deg(logic [BRG_W-1:0] a);
        logic [6:0]             idx;
        logic                   neg;
        logic signed [DIR_W-1:0] mag;
        if (a <= DEG_90)
        begin
            idx = a[6:0];
            neg = 1'b0;
        end
        else if (a <= DEG_180)
        begin
            idx = 7'(DEG_180 - a);
            neg = 1'b0;
        end
        else if (a <= DEG_270)
        begin
            idx = 7'(a - DEG_180);
            neg = 1'b1;
        end
        else
        begin
            idx = 7'(DEG_360 - a);
            neg = 1'b1;
        end
        mag = $signed({1'b0, SIN_TAB[idx]});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [DIR_W-1:0] cos_deg(logic [BRG_W-1:0] a);
        logic [BRG_W:0] s;
        s = {1'b0, a} + {1'b0, DEG_90};
        if (s >= {1'b0, DEG_360})
            s = s - {1'b0, DEG_360};
        return sin_deg(s[BRG_W-1:0]);
    endfunction

    function automatic logic [BRG_W-1:0] reduce_deg(logic [BRG_W-1:0] a);
        return (a >= DEG_360) ? a - DEG_360 : a;
    endfunction

    // one restoring step at quotient bit pos
    function automatic div_lane_t div_step(div_lane_t l, logic [DIV_W-1:0] d, int unsigned pos);
        div_lane_t        o;
        logic [CMP_W-1:0] sh;
        o = l;
        sh = CMP_W'(d) << pos;
        if (CMP_W'(l.rem) >= sh)
        begin
            o.rem = l.rem - sh[MAG_W-1:0];
            o.quo[pos] = 1'b1;
        end
        return o;
    endfunction

endpackage

// ----- src/bli_in_if.sv -----
interface bli_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       first_x;
    logic signed [31:0]       first_y;
    logic [8:0]               first_bearing;
    logic signed [31:0]       second_x;
    logic signed [31:0]       second_y;
    logic [8:0]               second_bearing;

    modport source (output valid, first_x, first_y, first_bearing,
                    second_x, second_y, second_bearing, input ready);
    modport sink (input valid, first_x, first_y, first_bearing,
                  second_x, second_y, second_bearing, output ready);
endinterface

// ----- src/bli_out_if.sv -----
interface bli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic               no_intersection;

    modport source (output valid, cross_x, cross_y, no_intersection, input ready);
    modport sink (input valid, cross_x, cross_y, no_intersection, output ready);
endinterface

// ----- src/bearing_line_intersection_core.sv -----
// channel   dir  payload
// item      in   first_x, first_y, first_bearing, second_x, second_y, second_bearing
// result    out  cross_x, cross_y, no_intersection
//
// one request per cycle while the skid register is empty; 50 register stages
// 8 front stages, 40 restoring divider stages (one quotient bit each) and 2 output stages
// rst_n clears all valid bits, the skid register's included; payload is not reset
// a stalled result moves into a skid register; while it is full the pipe holds
module bearing_line_intersection_core (
    input  logic      clk,
    input  logic      rst_n,
    bli_in_if.sink    item,
    bli_out_if.source result
);

    localparam int NS = bli_pkg::STAGE_N;
    localparam int QW = bli_pkg::QUOT_W;

    logic [NS-1:0] v_reg;
    logic          en;
    logic          skid_v_reg;

    // stage 0
    logic signed [bli_pkg::POS_W-1:0] px0_reg, py0_reg, qx0_reg, qy0_reg;
    logic [bli_pkg::BRG_W-1:0]        a0_reg, b0_reg;
    // stage 1
    logic signed [bli_pkg::POS_W-1:0]  px1_reg, py1_reg;
    logic signed [bli_pkg::DIFF_W-1:0] dx1_reg, dy1_reg;
    logic signed [bli_pkg::DIR_W-1:0]  dpx1_reg, dpy1_reg, dqx1_reg, dqy1_reg;
    // stage 2
    logic signed [bli_pkg::POS_W-1:0]  px2_reg, py2_reg;
    logic signed [bli_pkg::DIR_W-1:0]  dpx2_reg, dpy2_reg;
    logic signed [2*bli_pkg::DIR_W-1:0] t1_reg, t2_reg;
    logic signed [bli_pkg::DIFF_W+bli_pkg::DIR_W-1:0] u1_reg, u2_reg;
    // stage 3
    logic signed [bli_pkg::POS_W-1:0] px3_reg, py3_reg;
    logic signed [bli_pkg::DIR_W-1:0] dpx3_reg, dpy3_reg;
    logic signed [bli_pkg::DEN_W-1:0] den3_reg;
    logic signed [bli_pkg::NUM_W-1:0] num3_reg;
    // stage 4
    logic signed [bli_pkg::POS_W-1:0] px4_reg, py4_reg;
    logic signed [bli_pkg::DIR_W-1:0] dpx4_reg, dpy4_reg;
    logic [bli_pkg::DABS_W-1:0]       den4_reg;
    logic signed [bli_pkg::NUM_W-1:0] num4_reg;
    logic                             par4_reg;
    // stage 5
    logic signed [bli_pkg::POS_W-1:0] px5_reg, py5_reg;
    logic [bli_pkg::DABS_W-1:0]       den5_reg;
    logic                             par5_reg;
    logic signed [bli_pkg::PLO_W-1:0] plx5_reg, ply5_reg;
    logic signed [bli_pkg::PHI_W-1:0] phx5_reg, phy5_reg;
    // stage 6
    logic signed [bli_pkg::POS_W-1:0] px6_reg, py6_reg;
    logic [bli_pkg::DIV_W-1:0]        div2_6_reg;
    logic                             par6_reg;
    logic signed [bli_pkg::MUL_W-1:0] mx6_reg, my6_reg;
    // stage 7
    bli_pkg::div_side_t side7_reg;
    bli_pkg::div_lane_t lx7_reg, ly7_reg;
    // divider
    bli_pkg::div_side_t side_reg [QW];
    bli_pkg::div_lane_t lx_reg [QW];
    bli_pkg::div_lane_t ly_reg [QW];
    // offset stage
    logic signed [bli_pkg::POS_W-1:0] pxo_reg, pyo_reg;
    logic                             paro_reg;
    logic signed [bli_pkg::OFF_W-1:0] offx_reg, offy_reg;
    // output stage and skid
    logic signed [bli_pkg::POS_W-1:0] cx_reg, cy_reg, skid_x_reg, skid_y_reg;
    logic                             flag_reg, skid_f_reg;

    assign en = !skid_v_reg;
    assign item.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], item.valid};
    end

    // front stages
    logic signed [2*bli_pkg::DIR_W-1:0] t1_next, t2_next;
    logic signed [bli_pkg::DIFF_W+bli_pkg::DIR_W-1:0] u1_next, u2_next;
    logic signed [2*bli_pkg::DIR_W-1:0] den_next;
    logic signed [bli_pkg::DIFF_W+bli_pkg::DIR_W-1:0] num_next;
    logic signed [bli_pkg::DEN_W-1:0] den_abs_next;
    logic signed [bli_pkg::PLO_W-1:0] lo_next;
    logic signed [bli_pkg::PHI_W-1:0] hi_next;
    logic signed [bli_pkg::MUL_W-1:0] prx_next, pry_next, dext_next;
    logic signed [bli_pkg::MUL_W-1:0] mx_abs_next, my_abs_next;

    always_comb
    begin
        t1_next = dpx1_reg * dqy1_reg;
        t2_next = dpy1_reg * dqx1_reg;
        u1_next = dx1_reg * dqy1_reg;
        u2_next = dy1_reg * dqx1_reg;
        den_next = t1_reg - t2_reg;
        num_next = u1_reg - u2_reg;
        den_abs_next = den3_reg[bli_pkg::DEN_W-1] ? -den3_reg : den3_reg;
        lo_next = bli_pkg::PLO_W'($signed({1'b0, num4_reg[bli_pkg::LO_W-1:0]}));
        hi_next = bli_pkg::PHI_W'($signed(num4_reg[bli_pkg::NUM_W-1:bli_pkg::LO_W]));
        prx_next = (bli_pkg::MUL_W'(phx5_reg) <<< bli_pkg::LO_W) + bli_pkg::MUL_W'(plx5_reg);
        pry_next = (bli_pkg::MUL_W'(phy5_reg) <<< bli_pkg::LO_W) + bli_pkg::MUL_W'(ply5_reg);
        dext_next = bli_pkg::MUL_W'($signed({1'b0, den5_reg}));
        mx_abs_next = mx6_reg[bli_pkg::MUL_W-1] ? -mx6_reg : mx6_reg;
        my_abs_next = my6_reg[bli_pkg::MUL_W-1] ? -my6_reg : my6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px0_reg <= item.first_x;
            py0_reg <= item.first_y;
            qx0_reg <= item.second_x;
            qy0_reg <= item.second_y;
            a0_reg  <= bli_pkg::reduce_deg(item.first_bearing);
            b0_reg  <= bli_pkg::reduce_deg(item.second_bearing);

            px1_reg  <= px0_reg;
            py1_reg  <= py0_reg;
            dx1_reg  <= bli_pkg::DIFF_W'(qx0_reg) - bli_pkg::DIFF_W'(px0_reg);
            dy1_reg  <= bli_pkg::DIFF_W'(qy0_reg) - bli_pkg::DIFF_W'(py0_reg);
            dpx1_reg <= bli_pkg::sin_deg(a0_reg);
            dpy1_reg <= bli_pkg::cos_deg(a0_reg);
            dqx1_reg <= bli_pkg::sin_deg(b0_reg);
            dqy1_reg <= bli_pkg::cos_deg(b0_reg);

            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            dpx2_reg <= dpx1_reg;
            dpy2_reg <= dpy1_reg;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            u1_reg   <= u1_next;
            u2_reg   <= u2_next;

            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
            dpx3_reg <= dpx2_reg;
            dpy3_reg <= dpy2_reg;
            den3_reg <= den_next[bli_pkg::DEN_W-1:0];
            num3_reg <= num_next[bli_pkg::NUM_W-1:0];

            // denominator made positive, numerator follows
            px4_reg  <= px3_reg;
            py4_reg  <= py3_reg;
            dpx4_reg <= dpx3_reg;
            dpy4_reg <= dpy3_reg;
            den4_reg <= den_abs_next[bli_pkg::DABS_W-1:0];
            num4_reg <= den3_reg[bli_pkg::DEN_W-1] ? -num3_reg : num3_reg;
            par4_reg <= (den3_reg == '0);

            // d * N split into two partial products
            px5_reg  <= px4_reg;
            py5_reg  <= py4_reg;
            den5_reg <= den4_reg;
            par5_reg <= par4_reg;
            plx5_reg <= bli_pkg::PLO_W'(dpx4_reg * lo_next);
            ply5_reg <= bli_pkg::PLO_W'(dpy4_reg * lo_next);
            phx5_reg <= bli_pkg::PHI_W'(dpx4_reg * hi_next);
            phy5_reg <= bli_pkg::PHI_W'(dpy4_reg * hi_next);

            // M = 2*d*N + D, divided later by 2*D with floor
            px6_reg    <= px5_reg;
            py6_reg    <= py5_reg;
            par6_reg   <= par5_reg;
            div2_6_reg <= {den5_reg, 1'b0};
            mx6_reg    <= (prx_next <<< 1) + dext_next;
            my6_reg    <= (pry_next <<< 1) + dext_next;

            side7_reg.px   <= px6_reg;
            side7_reg.py   <= py6_reg;
            side7_reg.par  <= par6_reg;
            // parallel lines: divisor forced nonzero, result is discarded
            side7_reg.div2 <= par6_reg ? bli_pkg::DIV_W'(1) : div2_6_reg;
            lx7_reg.rem <= mx_abs_next[bli_pkg::MAG_W-1:0];
            lx7_reg.quo <= '0;
            lx7_reg.neg <= mx6_reg[bli_pkg::MUL_W-1];
            ly7_reg.rem <= my_abs_next[bli_pkg::MAG_W-1:0];
            ly7_reg.quo <= '0;
            ly7_reg.neg <= my6_reg[bli_pkg::MUL_W-1];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        bli_pkg::div_side_t side_in;
        bli_pkg::div_lane_t lx_in, ly_in;
        if (k == 0)
        begin : g_first
            assign side_in = side7_reg;
            assign lx_in = lx7_reg;
            assign ly_in = ly7_reg;
        end
        else
        begin : g_rest
            assign side_in = side_reg[k-1];
            assign lx_in = lx_reg[k-1];
            assign ly_in = ly_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                lx_reg[k] <= bli_pkg::div_step(lx_in, side_in.div2, QW - 1 - k);
                ly_reg[k] <= bli_pkg::div_step(ly_in, side_in.div2, QW - 1 - k);
            end
        end
    end

    logic [QW:0]                      qx_up, qy_up;
    logic signed [bli_pkg::OFF_W-1:0] qx_s, qy_s;
    logic signed [bli_pkg::SUM_W-1:0] sx, sy;
    logic signed [bli_pkg::POS_W-1:0] cx_next, cy_next;
    logic                             flag_next;

    always_comb
    begin
        // floor for negative numerators rounds the magnitude up
        qx_up = {1'b0, lx_reg[QW-1].quo}
              + (QW+1)'(lx_reg[QW-1].neg && (lx_reg[QW-1].rem != '0));
        qy_up = {1'b0, ly_reg[QW-1].quo}
              + (QW+1)'(ly_reg[QW-1].neg && (ly_reg[QW-1].rem != '0));
        qx_s = $signed(bli_pkg::OFF_W'(qx_up));
        qy_s = $signed(bli_pkg::OFF_W'(qy_up));

        sx = bli_pkg::SUM_W'(pxo_reg) + bli_pkg::SUM_W'(offx_reg);
        sy = bli_pkg::SUM_W'(pyo_reg) + bli_pkg::SUM_W'(offy_reg);
        flag_next = 1'b0;
        if (sx > bli_pkg::SUM_W'(bli_pkg::POS_MAX))
        begin
            cx_next = bli_pkg::POS_MAX;
            flag_next = 1'b1;
        end
        else if (sx < bli_pkg::SUM_W'(bli_pkg::POS_MIN))
        begin
            cx_next = bli_pkg::POS_MIN;
            flag_next = 1'b1;
        end
        else
            cx_next = sx[bli_pkg::POS_W-1:0];
        if (sy > bli_pkg::SUM_W'(bli_pkg::POS_MAX))
        begin
            cy_next = bli_pkg::POS_MAX;
            flag_next = 1'b1;
        end
        else if (sy < bli_pkg::SUM_W'(bli_pkg::POS_MIN))
        begin
            cy_next = bli_pkg::POS_MIN;
            flag_next = 1'b1;
        end
        else
            cy_next = sy[bli_pkg::POS_W-1:0];
        if (paro_reg)
        begin
            cx_next = '0;
            cy_next = '0;
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxo_reg  <= side_reg[QW-1].px;
            pyo_reg  <= side_reg[QW-1].py;
            paro_reg <= side_reg[QW-1].par;
            offx_reg <= lx_reg[QW-1].neg ? -qx_s : qx_s;
            offy_reg <= ly_reg[QW-1].neg ? -qy_s : qy_s;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            flag_reg <= flag_next;
        end
    end

    // skid register catches the result when the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_v_reg <= 1'b0;
        else if (skid_v_reg)
        begin
            if (result.ready)
                skid_v_reg <= 1'b0;
        end
        else if (v_reg[NS-1] && !result.ready)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_x_reg <= cx_reg;
            skid_y_reg <= cy_reg;
            skid_f_reg <= flag_reg;
        end
    end

    assign result.valid = skid_v_reg || v_reg[NS-1];
    assign result.cross_x = skid_v_reg ? skid_x_reg : cx_reg;
    assign result.cross_y = skid_v_reg ? skid_y_reg : cy_reg;
    assign result.no_intersection = skid_v_reg ? skid_f_reg : flag_reg;

endmodule

// ----- src/bli_checker.sv -----
module bli_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic        out_flag
);

    localparam int MAX_OUT = bli_pkg::STAGE_N + 1;

    logic [6:0] cnt_reg;
    logic       in_acc, out_acc;

    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_reg + 7'(in_acc) - 7'(out_acc);
    end

    // no result waiting means the input side is open
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input stalled with no result pending");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0) else $error("result with no request in flight");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(MAX_OUT)) else $error("too many requests in flight");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
        && $stable(out_flag)) else $error("stalled result changed");

endmodule

bind bearing_line_intersection_core bli_checker u_bli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.cross_x),
    .out_y     (result.cross_y),
    .out_flag  (result.no_intersection)
);

// ----- sim/bearing_line_intersection_core_tb.sv -----
module bearing_line_intersection_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [bli_pkg::POS_W-1:0] px;
        logic signed [bli_pkg::POS_W-1:0] py;
        logic [bli_pkg::BRG_W-1:0]        pb;
        logic signed [bli_pkg::POS_W-1:0] qx;
        logic signed [bli_pkg::POS_W-1:0] qy;
        logic [bli_pkg::BRG_W-1:0]        qb;
    } sighting_t;

    typedef struct {
        logic signed [bli_pkg::POS_W-1:0] x;
        logic signed [bli_pkg::POS_W-1:0] y;
        logic                             flag;
    } fix_t;

    typedef struct {
        sighting_t s;
        bit        typed;
        fix_t      fix;
    } row_t;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   n_bad;
    longint unsigned quarter_tab [0:90];
    fix_t fixes_due [$];

    bli_in_if  item_ch ();
    bli_out_if result_ch ();

    bearing_line_intersection_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned taylor_sine(int unsigned deg);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          acc;
        x = (longint'(deg) * 64'd3373259426 + 64'd90) / 64'd180;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        r = (longint'(acc) + 64'd512) >> 10;
        if (r > 64'd1048576)
            r = 64'd1048576;
        return r;
    endfunction

    function automatic longint heading_sin(int unsigned a);
        if (a <= 90)
            return longint'(quarter_tab[a]);
        if (a <= 180)
            return longint'(quarter_tab[180 - a]);
        if (a <= 270)
            return -longint'(quarter_tab[a - 180]);
        return -longint'(quarter_tab[360 - a]);
    endfunction

    function automatic longint capped_product(longint d, longint q);
        longint cap;
        longint ad;
        longint aq;
        cap = 64'sd1 << 62;
        if (d == 0 || q == 0)
            return 0;
        ad = d < 0 ? -d : d;
        aq = q < 0 ? -q : q;
        if (aq > cap / ad)
            return ((d < 0) != (q < 0)) ? -cap : cap;
        return d * q;
    endfunction

    function automatic longint step_along(longint d, longint qt, longint rem, longint den);
        longint num;
        longint div2;
        longint fl;
        num = 2 * (d * rem) + den;
        div2 = 2 * den;
        if (num >= 0)
            fl = num / div2;
        else
            fl = -((-num + div2 - 1) / div2);
        return capped_product(d, qt) + fl;
    endfunction

    function automatic fix_t predict_crossing(sighting_t s);
        fix_t   f;
        int unsigned a;
        int unsigned b;
        longint dpx;
        longint dpy;
        longint dqx;
        longint dqy;
        longint den;
        longint num;
        longint qt;
        longint rem;
        longint v [2];
        a = int'(s.pb) % 360;
        b = int'(s.qb) % 360;
        dpx = heading_sin(a);
        dpy = heading_sin((a + 90) % 360);
        dqx = heading_sin(b);
        dqy = heading_sin((b + 90) % 360);
        den = dpx * dqy - dpy * dqx;
        f.x = '0;
        f.y = '0;
        f.flag = 1'b1;
        if (den == 0)
            return f;
        num = (longint'(s.qx) - longint'(s.px)) * dqy - (longint'(s.qy) - longint'(s.py)) * dqx;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        qt = num / den;
        rem = num % den;
        v[0] = longint'(s.px) + step_along(dpx, qt, rem, den);
        v[1] = longint'(s.py) + step_along(dpy, qt, rem, den);
        f.flag = 1'b0;
        foreach (v[i])
        begin
            if (v[i] > 64'sd2147483647)
            begin
                v[i] = 64'sd2147483647;
                f.flag = 1'b1;
            end
            else if (v[i] < -64'sd2147483648)
            begin
                v[i] = -64'sd2147483648;
                f.flag = 1'b1;
            end
        end
        f.x = v[0][31:0];
        f.y = v[1][31:0];
        return f;
    endfunction

    function automatic logic signed [bli_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return $signed($urandom_range(0, 4095)) - 2048;
            default: return $signed($urandom_range(0, 2 ** 27)) - 2 ** 26;
        endcase
    endfunction

    function automatic sighting_t rand_sighting();
        sighting_t s;
        s.px = rand_pos();
        s.py = rand_pos();
        s.qx = rand_pos();
        s.qy = rand_pos();
        s.pb = ($urandom_range(0, 4) == 0) ? bli_pkg::BRG_W'($urandom_range(0, 511))
                                           : bli_pkg::BRG_W'($urandom_range(0, 359));
        case ($urandom_range(0, 9))
            0:       s.qb = s.pb;
            1:       s.qb = bli_pkg::BRG_W'((s.pb + 180) % 360);
            2:       s.qb = bli_pkg::BRG_W'((s.pb + 1) % 360);
            3:       s.qb = bli_pkg::BRG_W'($urandom_range(0, 511));
            default: s.qb = bli_pkg::BRG_W'($urandom_range(0, 359));
        endcase
        return s;
    endfunction

    task automatic send_sighting(sighting_t s, bit typed, fix_t fix);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.first_x        <= s.px;
        item_ch.first_y        <= s.py;
        item_ch.first_bearing  <= s.pb;
        item_ch.second_x       <= s.qx;
        item_ch.second_y       <= s.qy;
        item_ch.second_bearing <= s.qb;
        do
            @(posedge clk);
        while (!item_ch.ready);
        fixes_due.push_back(typed ? fix : predict_crossing(s));
    endtask

    // receiver stalls in bursts until the quiet tail
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        fix_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (fixes_due.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result x=%h y=%h flag=%b", result_ch.cross_x,
                             result_ch.cross_y, result_ch.no_intersection);
            end
            else
            begin
                want = fixes_due.pop_front();
                if (result_ch.cross_x !== want.x || result_ch.cross_y !== want.y ||
                    result_ch.no_intersection !== want.flag)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("crossing wrong: exp x=%h y=%h flag=%b got x=%h y=%h flag=%b",
                                 want.x, want.y, want.flag, result_ch.cross_x,
                                 result_ch.cross_y, result_ch.no_intersection);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("bearing_line_intersection_core: mismatch");
        $finish;
    end

    initial
    begin
        row_t rows [$];
        row_t r;
        fix_t par;
        fix_t none;
        int   cnt;
        par.x = '0;
        par.y = '0;
        par.flag = 1'b1;
        none = par;
        for (int i = 0; i <= 90; i++)
            quarter_tab[i] = taylor_sine(i);
        n_bad = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.first_x = '0;
        item_ch.first_y = '0;
        item_ch.first_bearing = '0;
        item_ch.second_x = '0;
        item_ch.second_y = '0;
        item_ch.second_bearing = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // parallel and coincident lines, typed expectations
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, par});
        rows.push_back('{'{100, 5, 0, 700, -9, 180}, 1, par});
        rows.push_back('{'{1, 2, 360, 3, 4, 0}, 1, par});
        rows.push_back('{'{bli_pkg::POS_MAX, bli_pkg::POS_MIN, 45,
                           bli_pkg::POS_MIN, bli_pkg::POS_MAX, 225}, 1, par});
        rows.push_back('{'{7, 7, 511, 8, 8, 151}, 1, par});
        rows.push_back('{'{-5, 3, 90, 6, 6, 270}, 1, par});
        rows.push_back('{'{-5, 3, 359, 6, 6, 179}, 1, par});
        // perpendicular, extremes, wrapped bearings, overflow
        rows.push_back('{'{65536, 0, 0, 0, 131072, 90}, 0, none});
        rows.push_back('{'{bli_pkg::POS_MAX, bli_pkg::POS_MAX, 0,
                           bli_pkg::POS_MIN, bli_pkg::POS_MIN, 90}, 0, none});
        rows.push_back('{'{bli_pkg::POS_MIN, bli_pkg::POS_MAX, 180,
                           bli_pkg::POS_MAX, bli_pkg::POS_MIN, 270}, 0, none});
        rows.push_back('{'{0, 0, 45, 65536, 0, 315}, 0, none});
        rows.push_back('{'{0, 0, 360, 65536, 0, 450}, 0, none});
        rows.push_back('{'{0, 0, 1, bli_pkg::POS_MAX, 0, 2}, 0, none});
        rows.push_back('{'{bli_pkg::POS_MIN, bli_pkg::POS_MIN, 89,
                           bli_pkg::POS_MAX, bli_pkg::POS_MAX, 90}, 0, none});
        rows.push_back('{'{-1, -1, 300, 1, 1, 30}, 0, none});
        rows.push_back('{'{123456, -654321, 137, -42, 99999, 211}, 0, none});
        rows.push_back('{'{0, 0, 0, 10, 0, 359}, 0, none});
        rows.push_back('{'{0, 0, 179, 10, 0, 181}, 0, none});
        rows.push_back('{'{bli_pkg::POS_MAX, 0, 256, 0, bli_pkg::POS_MIN, 128}, 0, none});
        foreach (rows[i])
            send_sighting(rows[i].s, rows[i].typed, rows[i].fix);

        cnt = 1650;
        for (int i = 0; i < cnt; i++)
        begin
            if (i == cnt - 200)
                quiet = 1'b1;
            r.s = rand_sighting();
            send_sighting(r.s, 1'b0, none);
        end
        item_ch.valid <= 1'b0;

        while (fixes_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (n_bad == 0)
            $display("bearing_line_intersection_core: match");
        else
            $display("bearing_line_intersection_core: mismatch");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/bli_pkg.sv
src/bli_in_if.sv
src/bli_out_if.sv
src/bearing_line_intersection_core.sv
src/bli_checker.sv
sim/bearing_line_intersection_core_tb.sv
